@@ hdl/cfs_pkg.sv @@
package cfs_pkg;

  // character codes
  localparam logic [15:0] ASCII_QUOTE   = 16'h0022;
  localparam logic [15:0] LEFT_QUOTE    = 16'h201C;
  localparam logic [15:0] RIGHT_QUOTE   = 16'h201D;
  localparam logic [15:0] DELIM_RESET   = 16'h002C;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DELIMITER   = 1'b0,
    CFG_COPY_QUOTES = 1'b1
  } cfs_cfg_idx_e;

  // parser mode
  typedef enum logic [0:0] {
    MODE_UNQUOTED = 1'b0,
    MODE_QUOTED   = 1'b1
  } cfs_mode_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPACE,
    ST_REL,
    ST_CHAR,
    ST_FIN,
    ST_FLUSH
  } cfs_state_e;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SPACE,
    OP_REL,
    OP_CHAR,
    OP_FIN,
    OP_FLUSH
  } cfs_op_e;

  typedef struct packed {
    cfs_op_e op;
    logic    go;
    logic    accept;
    logic    in_ready;
  } cfs_cmd_t;

  typedef struct packed {
    logic in_present;
    logic in_ws;
    logic in_end;
    logic end_q;
    logic qw;
    logic count_zero;
    logic rel_done;
    logic char_stay;
    logic pend;
    logic can_push;
  } cfs_status_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        out_char_valid;
    logic        field_done;
    logic        line_done;
    logic        space_overflow;
    logic        run_last;
  } cfs_result_t;

  function automatic logic is_ws(logic [15:0] c);
    return ((c >= 16'h0009) && (c <= 16'h000D)) || (c == 16'h0020);
  endfunction

endpackage

@@ hdl/cfs_in_if.sv @@
interface cfs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        char_present;
  logic        line_end;

  modport source (output valid, char_code, char_present, line_end, input ready);
  modport sink   (input valid, char_code, char_present, line_end, output ready);
endinterface

@@ hdl/cfs_out_if.sv @@
interface cfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_char;
  logic        out_char_valid;
  logic        field_done;
  logic        line_done;
  logic        space_overflow;
  logic        run_last;

  modport source (output valid, out_char, out_char_valid, field_done, line_done,
                  space_overflow, run_last, input ready);
  modport sink   (input valid, out_char, out_char_valid, field_done, line_done,
                  space_overflow, run_last, output ready);
endinterface

@@ hdl/cfs_ctrl.sv @@
module cfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  cfs_pkg::cfs_status_t status_i,
  output cfs_pkg::cfs_cmd_t    cmd_o
);

  cfs_pkg::cfs_state_e state_q, state_d, done_st;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // where a step goes once its last phase is through
  assign done_st = status_i.pend ? cfs_pkg::ST_FLUSH : cfs_pkg::ST_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority if (status_i.in_present && status_i.in_ws) begin
            state_d = cfs_pkg::ST_SPACE;
          end else if (status_i.in_present) begin
            state_d = status_i.count_zero ? cfs_pkg::ST_CHAR : cfs_pkg::ST_REL;
          end else if (status_i.in_end) begin
            state_d = cfs_pkg::ST_FIN;
          end else begin
            state_d = cfs_pkg::ST_IDLE;
          end
        end
      end
      cfs_pkg::ST_SPACE: begin
        if (status_i.can_push && !status_i.qw) begin
          state_d = status_i.end_q ? cfs_pkg::ST_FIN : done_st;
        end
      end
      cfs_pkg::ST_REL: begin
        if (status_i.can_push && status_i.rel_done) begin
          state_d = cfs_pkg::ST_CHAR;
        end
      end
      cfs_pkg::ST_CHAR: begin
        if (status_i.can_push && !status_i.char_stay) begin
          state_d = status_i.end_q ? cfs_pkg::ST_FIN : done_st;
        end
      end
      cfs_pkg::ST_FIN: begin
        if (status_i.can_push && !status_i.qw) begin
          state_d = cfs_pkg::ST_FLUSH;
        end
      end
      cfs_pkg::ST_FLUSH: begin
        if (status_i.can_push) begin
          state_d = cfs_pkg::ST_IDLE;
        end
      end
      default: state_d = cfs_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.go       = status_i.can_push;
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = cfs_pkg::OP_NONE;
    unique case (state_q)
      cfs_pkg::ST_IDLE:  cmd_o.in_ready = 1'b1;
      cfs_pkg::ST_SPACE: cmd_o.op = cfs_pkg::OP_SPACE;
      cfs_pkg::ST_REL:   cmd_o.op = cfs_pkg::OP_REL;
      cfs_pkg::ST_CHAR:  cmd_o.op = cfs_pkg::OP_CHAR;
      cfs_pkg::ST_FIN:   cmd_o.op = cfs_pkg::OP_FIN;
      cfs_pkg::ST_FLUSH: cmd_o.op = cfs_pkg::OP_FLUSH;
      default:           cmd_o.op = cfs_pkg::OP_NONE;
    endcase
    cmd_o.accept = cmd_o.in_ready && in_valid_i;
  end

endmodule

@@ hdl/cfs_datapath.sv @@
module cfs_datapath #(
  parameter int SPACE_HOLD_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [15:0]          in_char_i,
  input  logic                 in_present_i,
  input  logic                 in_end_i,
  input  cfs_pkg::cfs_cmd_t    cmd_i,
  output cfs_pkg::cfs_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfs_pkg::cfs_result_t out_res_o
);

  localparam int CNT_W = $clog2(SPACE_HOLD_DEPTH + 2);
  localparam int IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SPACE_HOLD_DEPTH);

  // configuration
  logic [15:0] delim_q;
  logic        copy_q;

  // parser state
  cfs_pkg::cfs_mode_e mode_q, mode_d;
  logic               qw_q, qw_d;
  logic [15:0]        wqc_q, wqc_d;
  logic               wwf_q, wwf_d;
  logic               inner_q, inner_d;
  logic               fs_q, fs_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rel_idx_q, rel_idx_d;
  logic               ovf_q, ovf_d;
  logic [15:0]        char_q;
  logic               end_q;

  // whitespace hold buffer
  logic [15:0] hold_q [SPACE_HOLD_DEPTH];
  logic [15:0] hold_rd_q;
  logic        hold_we;

  // staging and output registers
  cfs_pkg::cfs_result_t s_res_q, o_res_q, new_res, last_res;
  logic                 s_valid_q, o_valid_q;
  logic                 emit, push, flush, o_load, can_push, rel_done;

  // quote resolution
  cfs_pkg::cfs_mode_e rs_mode;
  logic               rs_inner, rs_emit;
  logic [15:0]        pc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= cfs_pkg::DELIM_RESET;
      copy_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfs_pkg::cfs_cfg_idx_e'(cfg_idx_i))
        cfs_pkg::CFG_DELIMITER:   delim_q <= cfg_data_i;
        cfs_pkg::CFG_COPY_QUOTES: copy_q  <= cfg_data_i[0];
        default:                  delim_q <= delim_q;
      endcase
    end
  end

  assign can_push = !s_valid_q || !o_valid_q || out_ready_i;
  assign rel_done = (rel_idx_q >= count_q) || (count_q > DEPTH_C);

  // resolving a lone quote toggles the span
  always_comb begin
    if (mode_q == cfs_pkg::MODE_QUOTED) begin
      rs_mode  = cfs_pkg::MODE_UNQUOTED;
      rs_inner = 1'b0;
      rs_emit  = inner_q;
    end else begin
      rs_mode  = cfs_pkg::MODE_QUOTED;
      rs_inner = inner_q || (copy_q && !wwf_q);
      rs_emit  = copy_q && !wwf_q;
    end
  end

  // character under work: a held space while releasing, else the latched one
  assign pc = (cmd_i.op == cfs_pkg::OP_REL) ? hold_rd_q : char_q;

  // one parser phase per cycle while the output side can take a result
  always_comb begin
    mode_d    = mode_q;
    qw_d      = qw_q;
    wqc_d     = wqc_q;
    wwf_d     = wwf_q;
    inner_d   = inner_q;
    fs_d      = fs_q;
    count_d   = count_q;
    rel_idx_d = rel_idx_q;
    ovf_d     = ovf_q;
    hold_we   = 1'b0;
    emit      = 1'b0;
    new_res   = '0;
    new_res.space_overflow = ovf_q;
    if (cmd_i.go) begin
      unique case (cmd_i.op)
        cfs_pkg::OP_SPACE: begin
          if (qw_q) begin
            qw_d    = 1'b0;
            mode_d  = rs_mode;
            inner_d = rs_inner;
            if (rs_emit) begin
              emit                   = 1'b1;
              new_res.out_char       = wqc_q;
              new_res.out_char_valid = 1'b1;
            end
          end else if (mode_q == cfs_pkg::MODE_UNQUOTED && !fs_q) begin
            // leading space of a field is dropped
            count_d = count_q;
          end else if (count_q > DEPTH_C) begin
            count_d = count_q;
          end else if (count_q == DEPTH_C) begin
            count_d = DEPTH_C + CNT_W'(1);
            ovf_d   = 1'b1;
          end else begin
            hold_we = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        cfs_pkg::OP_REL: begin
          if (rel_done) begin
            count_d   = '0;
            rel_idx_d = '0;
          end else begin
            rel_idx_d = rel_idx_q + CNT_W'(1);
            if (mode_q == cfs_pkg::MODE_QUOTED) begin
              emit                   = 1'b1;
              new_res.out_char       = pc;
              new_res.out_char_valid = 1'b1;
            end else if (fs_q) begin
              emit = 1'b1;
              if (pc == delim_q) begin
                new_res.field_done = 1'b1;
                fs_d               = 1'b0;
                inner_d            = 1'b0;
              end else begin
                new_res.out_char       = pc;
                new_res.out_char_valid = 1'b1;
              end
            end
          end
        end
        cfs_pkg::OP_CHAR: begin
          if (qw_q) begin
            qw_d = 1'b0;
            if (pc == cfs_pkg::ASCII_QUOTE) begin
              // doubled quote gives one literal
              emit                   = 1'b1;
              new_res.out_char       = wqc_q;
              new_res.out_char_valid = 1'b1;
            end else begin
              mode_d  = rs_mode;
              inner_d = rs_inner;
              if (rs_emit) begin
                emit                   = 1'b1;
                new_res.out_char       = wqc_q;
                new_res.out_char_valid = 1'b1;
              end
            end
          end else if (mode_q == cfs_pkg::MODE_QUOTED) begin
            if (pc == cfs_pkg::ASCII_QUOTE || pc == cfs_pkg::RIGHT_QUOTE) begin
              qw_d  = 1'b1;
              wqc_d = pc;
            end else begin
              emit                   = 1'b1;
              new_res.out_char       = pc;
              new_res.out_char_valid = 1'b1;
            end
          end else begin
            if (pc == cfs_pkg::ASCII_QUOTE || pc == cfs_pkg::LEFT_QUOTE) begin
              qw_d  = 1'b1;
              wqc_d = pc;
              wwf_d = !fs_q;
              fs_d  = 1'b1;
            end else if (pc == delim_q) begin
              emit               = 1'b1;
              new_res.field_done = 1'b1;
              fs_d               = 1'b0;
              inner_d            = 1'b0;
            end else begin
              emit                   = 1'b1;
              new_res.out_char       = pc;
              new_res.out_char_valid = 1'b1;
              fs_d                   = 1'b1;
            end
          end
        end
        cfs_pkg::OP_FIN: begin
          if (qw_q) begin
            qw_d    = 1'b0;
            mode_d  = rs_mode;
            inner_d = rs_inner;
            if (rs_emit) begin
              emit                   = 1'b1;
              new_res.out_char       = wqc_q;
              new_res.out_char_valid = 1'b1;
            end
          end else begin
            emit               = 1'b1;
            new_res.field_done = fs_q || (mode_q == cfs_pkg::MODE_QUOTED);
            new_res.line_done  = 1'b1;
            count_d            = '0;
            mode_d             = cfs_pkg::MODE_UNQUOTED;
            fs_d               = 1'b0;
            inner_d            = 1'b0;
            wwf_d              = 1'b0;
            ovf_d              = 1'b0;
          end
        end
        cfs_pkg::OP_FLUSH: emit = 1'b0;
        cfs_pkg::OP_NONE:  emit = 1'b0;
        default:           emit = 1'b0;
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cfs_pkg::MODE_UNQUOTED;
      qw_q      <= 1'b0;
      wqc_q     <= '0;
      wwf_q     <= 1'b0;
      inner_q   <= 1'b0;
      fs_q      <= 1'b0;
      count_q   <= '0;
      rel_idx_q <= '0;
      ovf_q     <= 1'b0;
      end_q     <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      qw_q      <= qw_d;
      wqc_q     <= wqc_d;
      wwf_q     <= wwf_d;
      inner_q   <= inner_d;
      fs_q      <= fs_d;
      count_q   <= count_d;
      rel_idx_q <= rel_idx_d;
      ovf_q     <= ovf_d;
      if (cmd_i.accept) begin
        end_q <= in_end_i;
      end
    end
  end

  // latched character and hold buffer; the read register fetches the
  // entry for the next release index
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= in_char_i;
    end
    if (hold_we) begin
      hold_q[count_q[IDX_W-1:0]] <= char_q;
    end
    hold_rd_q <= hold_q[rel_idx_d[IDX_W-1:0]];
  end

  // staging keeps one result back so the step's last one can be marked
  assign push   = emit;
  assign flush  = cmd_i.go && (cmd_i.op == cfs_pkg::OP_FLUSH);
  assign o_load = (push && s_valid_q) || flush;

  always_comb begin
    last_res          = s_res_q;
    last_res.run_last = flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (push) begin
        s_valid_q <= 1'b1;
      end else if (flush) begin
        s_valid_q <= 1'b0;
      end
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      s_res_q <= new_res;
    end
    if (o_load) begin
      o_res_q <= last_res;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_res_o   = o_res_q;

  // status to the controller
  assign status_o.in_present = in_present_i;
  assign status_o.in_ws      = cfs_pkg::is_ws(in_char_i);
  assign status_o.in_end     = in_end_i;
  assign status_o.end_q      = end_q;
  assign status_o.qw         = qw_q;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.rel_done   = rel_done;
  assign status_o.char_stay  = qw_q && (char_q != cfs_pkg::ASCII_QUOTE);
  assign status_o.pend       = s_valid_q || emit;
  assign status_o.can_push   = can_push;

endmodule

@@ hdl/csv_field_splitter.sv @@
// Sequencing: the idle state accepts a request, then one parser phase runs per
// cycle while the output can take results: a pending quote is resolved, held
// spaces are released before a character, a line end closes the line, and a
// flush phase marks the last result when the request yields results. An empty
// request returns to idle; a new request is taken only back in idle.
// Reset: rst_ni, asynchronous active low, clears control state and config only.
module csv_field_splitter #(
  parameter int SPACE_HOLD_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  cfs_in_if.sink      in_i,
  cfs_out_if.source   out_o
);

  cfs_pkg::cfs_cmd_t    cmd;
  cfs_pkg::cfs_status_t status;
  cfs_pkg::cfs_result_t res;

  // sequencer
  cfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // parser datapath
  cfs_datapath #(
    .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_char_i    (in_i.char_code),
    .in_present_i (in_i.char_present),
    .in_end_i     (in_i.line_end),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_res_o    (res)
  );

  assign in_i.ready           = cmd.in_ready;
  assign out_o.out_char       = res.out_char;
  assign out_o.out_char_valid = res.out_char_valid;
  assign out_o.field_done     = res.field_done;
  assign out_o.line_done      = res.line_done;
  assign out_o.space_overflow = res.space_overflow;
  assign out_o.run_last       = res.run_last;

endmodule

@@ hdl/cfs_checker.sv @@
module cfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_char_i,
  input logic        out_char_valid_i,
  input logic        field_done_i,
  input logic        line_done_i,
  input logic        run_last_i
);

  // a waiting request stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  // marker results carry a zero character
  a_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_char_valid_i |-> out_char_i == 16'h0000)
    else $error("marker result with nonzero character");

  // a character result never closes a field or line
  a_char_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_char_valid_i |-> !field_done_i && !line_done_i)
    else $error("character result with field or line mark");

  // line close is always the last result of its item
  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_done_i |-> run_last_i)
    else $error("line close not marked last");

endmodule

bind csv_field_splitter cfs_checker u_cfs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_char_i       (out_o.out_char),
  .out_char_valid_i (out_o.out_char_valid),
  .field_done_i     (out_o.field_done),
  .line_done_i      (out_o.line_done),
  .run_last_i       (out_o.run_last)
);
